FILE: hw/rtl/spi_register_transaction_sequencer_core_defines.svh
// assertion macros used by the spi register transaction sequencer rtl
`ifndef SPI_REGISTER_TRANSACTION_SEQUENCER_CORE_DEFINES_SVH
`define SPI_REGISTER_TRANSACTION_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define SRTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srts assertion failed");

// next-cycle implication, disabled while reset is held
`define SRTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srts assertion failed");

`endif

FILE: hw/rtl/srts_pkg.sv
// types and constants of the spi register transaction sequencer
package srts_pkg;

    // request codes
    localparam logic [2:0] REQ_LOAD  = 3'd0;
    localparam logic [2:0] REQ_WRITE = 3'd1;
    localparam logic [2:0] REQ_READ  = 3'd2;
    localparam logic [2:0] REQ_RXBYTE = 3'd3;
    localparam logic [2:0] REQ_TICK  = 3'd4;

    // sequencer modes, also the reported status
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_ADDR  = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_READ  = 3'd3;
    localparam logic [2:0] MODE_ERROR = 3'd4;

    // configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_DUMMY   = 1'b1;

    localparam logic [15:0] TIMEOUT_RST = 16'd2000;
    localparam logic [7:0]  DUMMY_RST   = 8'hFF;
    localparam logic [7:0]  WRITE_FLAG  = 8'h80;

    // one result beat before the store byte is merged in
    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       send_from_store;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [4:0] rx_index;
        logic       cs_active;
        logic [2:0] status;
        logic       done;
    } t_result;

endpackage

FILE: hw/rtl/srts_ram.sv
// generic single-port-write, registered-read ram
module srts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/srts_ctrl.sv
// transaction mode, counters and store access for one request beat
module srts_ctrl #(
    parameter int BUF_DEPTH = 32
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_accept,
    input  logic [2:0]                                     i_req_type,
    input  logic [6:0]                                     i_target_addr,
    input  logic [7:0]                                     i_data_byte,
    input  logic [4:0]                                     i_buf_index,
    input  logic [5:0]                                     i_xfer_count,
    input  logic [15:0]                                    i_timeout_ms,
    input  logic [7:0]                                     i_dummy_byte,
    output logic                                           o_wr_en,
    output logic [$clog2(BUF_DEPTH > 1 ? BUF_DEPTH : 2)-1:0] o_wr_addr,
    output logic [7:0]                                     o_wr_data,
    output logic [$clog2(BUF_DEPTH > 1 ? BUF_DEPTH : 2)-1:0] o_rd_addr,
    output srts_pkg::t_result                              o_result
);
    import srts_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH > 1 ? BUF_DEPTH : 2);
    localparam int CW = $clog2(BUF_DEPTH + 1);

    logic [2:0]    r_mode, n_mode;
    logic          r_is_read, n_is_read;
    logic [CW-1:0] r_tx_left, n_tx_left;
    logic [CW-1:0] r_rx_left, n_rx_left;
    logic [AW-1:0] r_tx_pos, n_tx_pos;
    logic [AW-1:0] r_rx_pos, n_rx_pos;
    logic [15:0]   r_elapsed, n_elapsed;
    logic          busy;
    logic [CW-1:0] count;
    t_result       res;

    assign busy = (r_mode == MODE_ADDR) || (r_mode == MODE_WRITE) || (r_mode == MODE_READ);

    // count limited to 1..depth
    always_comb begin
        if (i_xfer_count == 6'd0) begin
            count = CW'(1);
        end else if (32'(i_xfer_count) > BUF_DEPTH) begin
            count = CW'(BUF_DEPTH);
        end else begin
            count = CW'(i_xfer_count);
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_is_read = r_is_read;
        n_tx_left = r_tx_left;
        n_rx_left = r_rx_left;
        n_tx_pos  = r_tx_pos;
        n_rx_pos  = r_rx_pos;
        n_elapsed = r_elapsed;
        res       = '0;
        o_wr_en   = 1'b0;

        unique case (i_req_type) inside
            REQ_LOAD: begin
                o_wr_en = i_accept && (32'(i_buf_index) < BUF_DEPTH);
            end
            REQ_WRITE, REQ_READ: begin
                if (!busy) begin
                    n_mode         = MODE_ADDR;
                    n_is_read      = (i_req_type == REQ_READ);
                    n_tx_left      = (i_req_type == REQ_READ) ? '0 : count;
                    n_rx_left      = (i_req_type == REQ_READ) ? count : '0;
                    n_tx_pos       = '0;
                    n_rx_pos       = '0;
                    n_elapsed      = '0;
                    res.send_valid = 1'b1;
                    res.send_byte  = (i_req_type == REQ_READ) ? {1'b0, i_target_addr}
                                                              : (WRITE_FLAG | {1'b0, i_target_addr});
                end
            end
            REQ_RXBYTE: begin
                unique case (r_mode)
                    MODE_ADDR: begin
                        res.send_valid = 1'b1;
                        if (r_is_read) begin
                            n_mode        = MODE_READ;
                            res.send_byte = i_dummy_byte;
                        end else begin
                            // first data byte, the answer to the address is dropped
                            n_mode              = MODE_WRITE;
                            res.send_from_store = 1'b1;
                            n_tx_pos            = r_tx_pos + AW'(1);
                            if (r_tx_left != '0) begin
                                n_tx_left = r_tx_left - CW'(1);
                            end
                        end
                    end
                    MODE_WRITE: begin
                        if (r_tx_left != '0) begin
                            res.send_valid      = 1'b1;
                            res.send_from_store = 1'b1;
                            n_tx_pos            = r_tx_pos + AW'(1);
                            n_tx_left           = r_tx_left - CW'(1);
                        end else begin
                            n_mode   = MODE_IDLE;
                            res.done = 1'b1;
                        end
                    end
                    MODE_READ: begin
                        if (r_rx_left != '0) begin
                            res.rx_valid = 1'b1;
                            res.rx_byte  = i_data_byte;
                            res.rx_index = 5'(32'(r_rx_pos));
                            n_rx_pos     = r_rx_pos + AW'(1);
                            n_rx_left    = r_rx_left - CW'(1);
                        end
                        if (n_rx_left == '0) begin
                            n_mode   = MODE_IDLE;
                            res.done = 1'b1;
                        end else begin
                            res.send_valid = 1'b1;
                            res.send_byte  = i_dummy_byte;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            REQ_TICK: begin
                if (busy) begin
                    if (r_elapsed >= i_timeout_ms) begin
                        n_mode   = MODE_ERROR;
                        res.done = 1'b1;
                    end else begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                end
            end
            default: begin
            end
        endcase

        res.status    = n_mode;
        res.cs_active = (n_mode == MODE_ADDR) || (n_mode == MODE_WRITE)
                        || (n_mode == MODE_READ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_is_read <= 1'b0;
            r_tx_left <= '0;
            r_rx_left <= '0;
            r_tx_pos  <= '0;
            r_rx_pos  <= '0;
            r_elapsed <= '0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_is_read <= n_is_read;
            r_tx_left <= n_tx_left;
            r_rx_left <= n_rx_left;
            r_tx_pos  <= n_tx_pos;
            r_rx_pos  <= n_rx_pos;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_wr_addr = AW'(32'(i_buf_index));
    assign o_wr_data = i_data_byte;
    assign o_rd_addr = r_tx_pos;
    assign o_result  = res;

endmodule

FILE: hw/rtl/spi_register_transaction_sequencer_core.sv
// top level of the spi register transaction sequencer
// latency: a request beat gives its one result beat on the cycle after acceptance
// throughput: one beat per cycle unless results stall, set by single store reads and writes
// the transmit store read is issued at acceptance and merged at the output register
// reset: synchronous active low, clears mode, counters and the output valid
// the transmit store has no reset and no clearing pass; entries are valid once loaded
`include "spi_register_transaction_sequencer_core_defines.svh"
module spi_register_transaction_sequencer_core #(
    parameter int BUF_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // target_addr[6:0], data_byte[14:7], buf_index[19:15], xfer_count[25:20], zero pad above
    input  logic [31:0] i_s_tdata,
    // req_type[2:0]
    input  logic [2:0]  i_s_tuser,
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // send_valid[0], send_byte[8:1], rx_valid[9], rx_byte[17:10], rx_index[22:18],
    // chip_select_active[23], status[26:24], zero pad above
    output logic [31:0] o_m_tdata,
    // done_res: transaction finished or aborted with this beat
    output logic        o_m_tlast,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import srts_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH > 1 ? BUF_DEPTH : 2);

    logic          accept;
    logic [15:0]   r_timeout_ms;
    logic [7:0]    r_dummy_byte;
    logic          r_m_valid;
    t_result       r_res;
    t_result       result;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [7:0]    send_byte;

    // output register parts the two sides; a new beat enters as the old one leaves
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms <= TIMEOUT_RST;
            r_dummy_byte <= DUMMY_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT: r_timeout_ms <= i_cfg_data;
                CFG_DUMMY:   r_dummy_byte <= i_cfg_data[7:0];
                default:     r_timeout_ms <= r_timeout_ms;
            endcase
        end
    end

    srts_ctrl #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_req_type    (i_s_tuser),
        .i_target_addr (i_s_tdata[6:0]),
        .i_data_byte   (i_s_tdata[14:7]),
        .i_buf_index   (i_s_tdata[19:15]),
        .i_xfer_count  (i_s_tdata[25:20]),
        .i_timeout_ms  (r_timeout_ms),
        .i_dummy_byte  (r_dummy_byte),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_addr     (rd_addr),
        .o_result      (result)
    );

    // loads write and sends read at the accepting edge, so a load is always
    // visible to any later beat and no forwarding path is needed
    srts_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_tx_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result register; read data of the store holds with it while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= result;
        end
    end

    assign send_byte = r_res.send_from_store ? rd_data : r_res.send_byte;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tlast  = r_res.done;
    assign o_m_tdata  = {5'd0, r_res.status, r_res.cs_active, r_res.rx_index,
                         r_res.rx_byte, r_res.rx_valid, send_byte, r_res.send_valid};

    // a finished or aborted transaction always leaves chip select released
    `SRTS_ASSERT_IMP(a_done_releases_cs, i_clk, i_rst_n, r_m_valid && r_res.done,
        !r_res.cs_active)
    // a read byte that does not end the read always clocks in the next one
    `SRTS_ASSERT_IMP(a_rx_continues, i_clk, i_rst_n,
        r_m_valid && r_res.rx_valid && !r_res.done,
        r_res.send_valid && (r_res.status == MODE_READ))
    // store bytes go out only in write mode
    `SRTS_ASSERT_IMP(a_store_in_write, i_clk, i_rst_n, r_m_valid && r_res.send_from_store,
        r_res.send_valid && (r_res.status == MODE_WRITE))
    // every accepted beat shows a result on the next cycle
    `SRTS_ASSERT_NXT(a_accept_gives_result, i_clk, i_rst_n, accept, o_m_tvalid)

endmodule

FILE: verif/spi_register_transaction_sequencer_core_test.sv
// self-checking testbench for the spi register transaction sequencer core
module spi_register_transaction_sequencer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srts_pkg::*;

    localparam int STORE_DEPTH = 32;
    localparam int RUN_LIMIT   = 200000;
    localparam int IDLE_PCT    = 11;

    // one result beat as the sequencer reports it
    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [4:0] rx_index;
        logic       cs_active;
        logic [2:0] status;
        logic       done;
    } t_seq_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic [2:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    spi_register_transaction_sequencer_core #(
        .BUF_DEPTH(STORE_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // sequencer state as the predictor sees it
    logic [15:0] cfg_timeout_ms = TIMEOUT_RST;
    logic [7:0]  cfg_dummy_byte = DUMMY_RST;
    logic [2:0]  seq_mode       = MODE_IDLE;
    logic        seq_is_read    = 1'b0;
    logic [7:0]  tx_mem [STORE_DEPTH];
    int          tx_left        = 0;
    int          rx_left        = 0;
    int          tx_pos         = 0;
    int          rx_pos         = 0;
    logic [15:0] elapsed_ms     = '0;

    t_seq_beat   expected_beats[$];
    int          n_fail      = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;
    bit          gaps_on     = 1'b1;

    function automatic bit seq_busy();
        return seq_mode == MODE_ADDR || seq_mode == MODE_WRITE || seq_mode == MODE_READ;
    endfunction

    // next preloaded byte of a write, the position runs on past the last byte
    function automatic logic [7:0] next_store_byte();
        logic [7:0] b;
        b = (tx_pos < STORE_DEPTH) ? tx_mem[tx_pos] : 8'h00;
        tx_pos++;
        if (tx_left > 0) tx_left--;
        return b;
    endfunction

    // advances the predicted state by one request and returns the result beat
    function automatic t_seq_beat step_sequencer(input logic [2:0] req, input logic [6:0] addr,
            input logic [7:0] data, input logic [4:0] idx, input logic [5:0] cnt);
        t_seq_beat r;
        int        n;
        r = '0;
        if (req == REQ_LOAD) begin
            tx_mem[idx] = data;
        end else if (req == REQ_WRITE || req == REQ_READ) begin
            // a start while busy is dropped, a start from error begins afresh
            if (!seq_busy()) begin
                n = (cnt == 0) ? 1 : ((cnt > STORE_DEPTH) ? STORE_DEPTH : int'(cnt));
                seq_mode    = MODE_ADDR;
                seq_is_read = (req == REQ_READ);
                tx_left     = seq_is_read ? 0 : n;
                rx_left     = seq_is_read ? n : 0;
                tx_pos      = 0;
                rx_pos      = 0;
                elapsed_ms  = '0;
                r.send_valid = 1'b1;
                r.send_byte  = seq_is_read ? {1'b0, addr} : ({1'b0, addr} | WRITE_FLAG);
            end
        end else if (req == REQ_RXBYTE) begin
            if (seq_mode == MODE_ADDR) begin
                // the byte answering the address is thrown away
                r.send_valid = 1'b1;
                if (seq_is_read) begin
                    seq_mode    = MODE_READ;
                    r.send_byte = cfg_dummy_byte;
                end else begin
                    seq_mode    = MODE_WRITE;
                    r.send_byte = next_store_byte();
                end
            end else if (seq_mode == MODE_WRITE) begin
                if (tx_left > 0) begin
                    r.send_valid = 1'b1;
                    r.send_byte  = next_store_byte();
                end else begin
                    seq_mode = MODE_IDLE;
                    r.done   = 1'b1;
                end
            end else if (seq_mode == MODE_READ) begin
                if (rx_left > 0) begin
                    r.rx_valid = 1'b1;
                    r.rx_byte  = data;
                    r.rx_index = 5'(rx_pos);
                    rx_pos++;
                    rx_left--;
                end
                if (rx_left == 0) begin
                    seq_mode = MODE_IDLE;
                    r.done   = 1'b1;
                end else begin
                    r.send_valid = 1'b1;
                    r.send_byte  = cfg_dummy_byte;
                end
            end
        end else if (req == REQ_TICK) begin
            if (seq_busy()) begin
                if (elapsed_ms >= cfg_timeout_ms) begin
                    seq_mode = MODE_ERROR;
                    r.done   = 1'b1;
                end else begin
                    elapsed_ms = elapsed_ms + 16'd1;
                end
            end
        end
        r.cs_active = seq_busy();
        r.status    = seq_mode;
        return r;
    endfunction

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
            n_fail++;
        end
    endtask

    // watches every handshake: config and request beats feed the predictor,
    // result beats are checked against the oldest prediction
    always @(posedge i_clk) begin
        t_seq_beat want;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_TIMEOUT) cfg_timeout_ms = i_cfg_data;
            else cfg_dummy_byte = i_cfg_data[7:0];
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            expected_beats.push_back(step_sequencer(i_s_tuser, i_s_tdata[6:0],
                i_s_tdata[14:7], i_s_tdata[19:15], i_s_tdata[25:20]));
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %h last %b",
                    $time, o_m_tdata, o_m_tlast);
                n_fail++;
            end else begin
                want = expected_beats.pop_front();
                check_field("send_valid", want.send_valid, o_m_tdata[0]);
                check_field("send_byte", want.send_byte, o_m_tdata[8:1]);
                check_field("rx_valid", want.rx_valid, o_m_tdata[9]);
                check_field("rx_byte", want.rx_byte, o_m_tdata[17:10]);
                check_field("rx_index", want.rx_index, o_m_tdata[22:18]);
                check_field("chip_select_active", want.cs_active, o_m_tdata[23]);
                check_field("status", want.status, o_m_tdata[26:24]);
                check_field("done_res", want.done, o_m_tlast);
            end
        end
    end

    // result side backpressure
    always @(posedge i_clk) begin
        i_m_tready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("spi_register_transaction_sequencer_core verification failed");
            $finish;
        end
    end

    // one request beat, with a random idle cycle ahead of it
    task automatic send_request(input logic [2:0] req, input logic [6:0] addr,
            input logic [7:0] data, input logic [4:0] idx, input logic [5:0] cnt);
        if (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {6'd0, cnt, idx, data, addr};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_noise();
        send_request(3'($urandom_range(0, 7)), 7'($urandom), 8'($urandom), 5'($urandom),
            6'($urandom_range(0, 63)));
    endtask

    // sender holds off until every predicted beat has been seen
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_config(input logic idx, input logic [15:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // read straight after reset, so the reset filler byte shows
    task automatic test_reset_values();
        send_request(REQ_READ, 7'h7F, 8'h00, 5'd0, 6'd1);
        send_request(REQ_RXBYTE, 7'h00, 8'h00, 5'd0, 6'd0);
        send_request(REQ_RXBYTE, 7'h00, 8'hFF, 5'd0, 6'd0);
    endtask

    // every store entry gets loaded before any write can reach it
    task automatic fill_store();
        logic [7:0] b;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            b = (i == 0) ? 8'h00 : ((i == STORE_DEPTH - 1) ? 8'hFF : 8'($urandom));
            send_request(REQ_LOAD, 7'($urandom), b, 5'(i), 6'($urandom));
        end
    endtask

    task automatic test_write_path();
        // count of zero is raised to one
        send_request(REQ_WRITE, 7'h00, 8'h00, 5'd0, 6'd0);
        send_request(REQ_RXBYTE, 7'h00, 8'h00, 5'd0, 6'd0);
        send_request(REQ_RXBYTE, 7'h00, 8'h00, 5'd0, 6'd0);
        // load and starts while busy, tick within the limit
        send_request(REQ_WRITE, 7'h55, 8'h00, 5'd0, 6'd3);
        send_request(REQ_RXBYTE, 7'h00, 8'h3C, 5'd0, 6'd0);
        send_request(REQ_LOAD, 7'h00, 8'hA5, 5'd1, 6'd0);
        send_request(REQ_READ, 7'h12, 8'h00, 5'd0, 6'd4);
        send_request(REQ_WRITE, 7'h34, 8'h00, 5'd0, 6'd2);
        send_request(REQ_TICK, 7'h00, 8'h00, 5'd0, 6'd0);
        send_request(REQ_RXBYTE, 7'h00, 8'h00, 5'd0, 6'd0);
        send_request(REQ_RXBYTE, 7'h00, 8'h00, 5'd0, 6'd0);
        send_request(REQ_RXBYTE, 7'h00, 8'h00, 5'd0, 6'd0);
    endtask

    // received byte and tick when idle, unknown request codes
    task automatic test_ignored_requests();
        send_request(REQ_RXBYTE, 7'h7F, 8'hFF, 5'h1F, 6'h3F);
        send_request(REQ_TICK, 7'h7F, 8'hFF, 5'h1F, 6'h3F);
        for (int c = 5; c < 8; c++) send_request(3'(c), 7'h7F, 8'hFF, 5'h1F, 6'h3F);
    endtask

    task automatic test_timeout();
        // zero limit: first tick of a transaction errors
        write_config(CFG_TIMEOUT, 16'd0);
        write_config(CFG_DUMMY, 16'h0000);
        send_request(REQ_READ, 7'h2A, 8'h00, 5'd0, 6'd2);
        send_request(REQ_RXBYTE, 7'h00, 8'h11, 5'd0, 6'd0);
        send_request(REQ_TICK, 7'h00, 8'h00, 5'd0, 6'd0);
        // in error: received byte and tick ignored, a start begins again
        send_request(REQ_RXBYTE, 7'h00, 8'h22, 5'd0, 6'd0);
        send_request(REQ_TICK, 7'h00, 8'h00, 5'd0, 6'd0);
        send_request(REQ_WRITE, 7'h7F, 8'h00, 5'd0, 6'd1);
        send_request(REQ_TICK, 7'h00, 8'h00, 5'd0, 6'd0);
        // limit of one: second tick errors
        write_config(CFG_TIMEOUT, 16'd1);
        send_request(REQ_READ, 7'h15, 8'h00, 5'd0, 6'd1);
        send_request(REQ_TICK, 7'h00, 8'h00, 5'd0, 6'd0);
        send_request(REQ_TICK, 7'h00, 8'h00, 5'd0, 6'd0);
    endtask

    // mostly whole transactions with ticks and noise mixed in
    task automatic run_random_phase(input int n_items, input int tick_pct, input bit long_xfers);
        int         stop_at;
        int         cnt;
        int         n;
        logic [2:0] req;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 30) begin
                send_noise();
            end else begin
                req = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
                if (long_xfers && $urandom_range(0, 99) < 30) cnt = $urandom_range(17, 63);
                else if ($urandom_range(0, 99) < 5) cnt = 0;
                else cnt = $urandom_range(1, 6);
                n = (cnt == 0) ? 1 : ((cnt > STORE_DEPTH) ? STORE_DEPTH : cnt);
                send_request(req, 7'($urandom), 8'($urandom), 5'($urandom), 6'(cnt));
                // address answer plus one byte per data byte, for reads and writes alike
                for (int k = 0; k <= n; k++) begin
                    if ($urandom_range(0, 99) < tick_pct) begin
                        send_request(REQ_TICK, 7'($urandom), 8'($urandom), 5'($urandom),
                            6'($urandom));
                    end
                    if ($urandom_range(0, 99) < 5) send_noise();
                    send_request(REQ_RXBYTE, 7'($urandom), 8'($urandom), 5'($urandom),
                        6'($urandom));
                end
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= REQ_LOAD;
        i_m_tready  <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_TIMEOUT;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        fill_store();
        test_write_path();
        test_ignored_requests();
        test_timeout();

        // short limit, idling on both sides
        write_config(CFG_TIMEOUT, 16'd6);
        write_config(CFG_DUMMY, 16'($urandom_range(0, 255)));
        run_random_phase(140, 20, 1'b0);

        // widest limit, long transfers, no idling at all
        write_config(CFG_TIMEOUT, 16'hFFFF);
        write_config(CFG_DUMMY, 16'h00FF);
        gaps_on = 1'b0;
        run_random_phase(170, 10, 1'b1);
        gaps_on = 1'b1;

        // tight limit, frequent errors
        write_config(CFG_TIMEOUT, 16'($urandom_range(1, 4)));
        write_config(CFG_DUMMY, 16'($urandom_range(0, 255)));
        run_random_phase(130, 25, 1'b0);

        drain_results();
        repeat (4) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("spi_register_transaction_sequencer_core verification clean");
        end else begin
            $display("spi_register_transaction_sequencer_core verification failed");
        end
        $finish;
    end

endmodule
